@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands with clock and synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ design/rgbaoc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbaoc_pkg
// types, format codes and divide-by-255 helper for the rgba over compositor
// ----------------------------------------------------------------------------
`default_nettype none

package rgbaoc_pkg;

  localparam int FMT_W = 2;

  localparam logic [FMT_W-1:0] FMT_RGBA = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGR  = 2'd2;

  localparam logic [7:0] ALPHA_MAX = 8'd255;

  typedef logic [2:0][7:0]  chan3_t;
  typedef logic [2:0][15:0] prod3_t;

  // products of destination alpha with destination colors, and of the inverted alphas
  typedef struct packed {
    logic             rgba;
    logic             last;
    logic             keep_dst;
    logic             copy_src;
    logic [7:0]       sa;
    logic [7:0]       da;
    chan3_t           s;
    chan3_t           d;
    prod3_t           prod;
    logic [15:0]      aprod;
  } st1_t;

  // premultiplied destination and signed difference magnitude
  typedef struct packed {
    logic             rgba;
    logic             last;
    logic             keep_dst;
    logic             copy_src;
    logic [7:0]       sa;
    logic [7:0]       da;
    logic [7:0]       oa;
    chan3_t           s;
    chan3_t           d;
    chan3_t           pd;
    chan3_t           mag;
    logic [2:0]       neg;
  } st2_t;

  // alpha-weighted difference
  typedef struct packed {
    logic             rgba;
    logic             last;
    logic             keep_dst;
    logic             copy_src;
    logic [7:0]       sa;
    logic [7:0]       da;
    logic [7:0]       oa;
    chan3_t           s;
    chan3_t           d;
    chan3_t           pd;
    prod3_t           m;
    logic [2:0]       neg;
  } st3_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ design/rgba_over_compositor_unit.sv @@
// ----------------------------------------------------------------------------
// rgba_over_compositor_unit
// composites an 8-bit rgba source pixel over a destination pixel
//
// s_tdata carries source and destination pixel, s_tlast marks end of run.
// m_tdata carries the new destination pixel, m_tlast follows s_tlast.
// cfg_we / cfg_wdata write the destination format (rgba, rgb, bgr); write it
// only while no beat is in flight.
// Four register stages: alpha products, divide and difference, weight
// multiply, divide and final select. A beat accepted into the first stage moves
// through the second and third stages to the output stage, where it shows on m_tvalid.
// One beat per clock is accepted and delivered while m_tready stays high.
// Each stage holds its beat when the stage after it is full and blocked, so
// a stall on m_tready fills empty stages first, then drops s_tready; no beat
// is lost or repeated.
// Reset empties all stages and sets the format to rgba.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgba_over_compositor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rgbaoc_pkg::FMT_W-1:0]  cfg_wdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // src_red, src_green, src_blue, src_alpha, dst_byte0, dst_byte1,
  // dst_byte2, dst_alpha
  input  wire logic [63:0]                   s_tdata,
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_byte0, out_byte1, out_byte2, out_alpha
  output logic [31:0]                        m_tdata,
  output logic                               m_tlast
);

  import rgbaoc_pkg::*;

  logic [FMT_W-1:0] dest_format;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  st1_t p1, p1_next;
  st2_t p2, p2_next;
  st3_t p3, p3_next;
  logic [31:0] out_next;
  logic        out_rgba;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v4;

  // stage 1: source select and alpha products
  always_comb begin
    logic [7:0] sr, sg, sb, sa, d0, d1, d2, da;
    sr = s_tdata[7:0];
    sg = s_tdata[15:8];
    sb = s_tdata[23:16];
    sa = s_tdata[31:24];
    d0 = s_tdata[39:32];
    d1 = s_tdata[47:40];
    d2 = s_tdata[55:48];
    da = s_tdata[63:56];
    p1_next.rgba     = (dest_format == FMT_RGBA);
    p1_next.last     = s_tlast;
    p1_next.keep_dst = (sa == 8'd0);
    p1_next.copy_src = (da == 8'd0) || (sa == ALPHA_MAX);
    p1_next.sa       = sa;
    p1_next.da       = da;
    p1_next.s[1]     = sg;
    if (dest_format == FMT_BGR) begin
      p1_next.s[0] = sb;
      p1_next.s[2] = sr;
    end else begin
      p1_next.s[0] = sr;
      p1_next.s[2] = sb;
    end
    p1_next.d[0]    = d0;
    p1_next.d[1]    = d1;
    p1_next.d[2]    = d2;
    p1_next.prod[0] = {8'd0, da} * {8'd0, d0};
    p1_next.prod[1] = {8'd0, da} * {8'd0, d1};
    p1_next.prod[2] = {8'd0, da} * {8'd0, d2};
    p1_next.aprod   = {8'd0, ALPHA_MAX - sa} * {8'd0, ALPHA_MAX - da};
  end

  // stage 2: destination (premultiplied in rgba), output alpha, difference magnitude and sign
  always_comb begin
    logic [7:0] pd;
    p2_next.rgba     = p1.rgba;
    p2_next.last     = p1.last;
    p2_next.keep_dst = p1.keep_dst;
    p2_next.copy_src = p1.copy_src;
    p2_next.sa       = p1.sa;
    p2_next.da       = p1.da;
    p2_next.oa       = ALPHA_MAX - div255(p1.aprod);
    p2_next.s        = p1.s;
    p2_next.d        = p1.d;
    for (int i = 0; i < 3; i++) begin
      pd = p1.rgba ? div255(p1.prod[i]) : p1.d[i];
      p2_next.pd[i]  = pd;
      p2_next.neg[i] = (p1.s[i] < pd);
      p2_next.mag[i] = (p1.s[i] < pd) ? (pd - p1.s[i]) : (p1.s[i] - pd);
    end
  end

  // stage 3: weight by source alpha
  always_comb begin
    p3_next.rgba     = p2.rgba;
    p3_next.last     = p2.last;
    p3_next.keep_dst = p2.keep_dst;
    p3_next.copy_src = p2.copy_src;
    p3_next.sa       = p2.sa;
    p3_next.da       = p2.da;
    p3_next.oa       = p2.oa;
    p3_next.s        = p2.s;
    p3_next.d        = p2.d;
    p3_next.pd       = p2.pd;
    p3_next.neg      = p2.neg;
    for (int i = 0; i < 3; i++) begin
      p3_next.m[i] = {8'd0, p2.sa} * {8'd0, p2.mag[i]};
    end
  end

  // stage 4: divide, apply sign, pick bypass cases
  always_comb begin
    chan3_t     blend;
    logic [7:0] q;
    for (int i = 0; i < 3; i++) begin
      q        = div255(p3.m[i]);
      blend[i] = p3.neg[i] ? (p3.pd[i] - q) : (p3.pd[i] + q);
    end
    priority if (p3.rgba && p3.keep_dst) begin
      out_next = {p3.da, p3.d[2], p3.d[1], p3.d[0]};
    end else if (p3.rgba && p3.copy_src) begin
      out_next = {p3.sa, p3.s[2], p3.s[1], p3.s[0]};
    end else if (p3.rgba) begin
      out_next = {p3.oa, blend[2], blend[1], blend[0]};
    end else begin
      out_next = {8'd0, blend[2], blend[1], blend[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_format <= FMT_RGBA;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (cfg_we) dest_format <= cfg_wdata;
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) p1 <= p1_next;
    if (rdy2 && v1) p2 <= p2_next;
    if (rdy3 && v2) p3 <= p3_next;
    if (rdy4 && v3) begin
      m_tdata  <= out_next;
      m_tlast  <= p3.last;
      out_rgba <= p3.rgba;
    end
  end

  `ASSERT_IMPL(a_ready_on_bubble, clk, rst, !(v1 && v2 && v3 && v4), s_tready)
  `ASSERT_NEXT(a_stage1_hold, clk, rst, v1 && !rdy2, v1 && $stable(p1))
  `ASSERT_IMPL(a_alpha_zero, clk, rst, m_tvalid && !out_rgba, m_tdata[31:24] == 8'd0)

endmodule

`default_nettype wire
